FILE: rtl/core/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int NUM_BUCKETS = 16;
  localparam int CHAIN_DEPTH = 8;
  localparam int SLOT_COUNT  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int CW  = $clog2(CHAIN_DEPTH);
  localparam int LW  = $clog2(CHAIN_DEPTH + 1);
  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int NBW = $clog2(NUM_BUCKETS + 1);
  localparam int KEY_W = 31;
  localparam int PAY_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic [4:0] BUCKETS_RESET = 5'd10;
endpackage

FILE: rtl/core/chained_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate-chaining hash table: insert, delete, search on 31-bit keys.
// ----------------------------------------------------------------------------
// One word is taken per start (when busy is low). Exactly one result word is
// shown on done for one cycle, and the receiver cannot stall it. done comes
// in the same cycle as busy falls.
// Steps per item:
// - Every item first finds its bucket: key mod bucket_count, worked out by a
//   restoring divider that makes one quotient bit a cycle through a shared
//   subtractor.
// - A lookup state (S_LOOK) follows. Insert and the unused code finish there.
// - Delete and search then scan the chain one entry per cycle, behind a
//   registered read of the slot memory, and finish in S_WAIT. A search hit
//   ends at the matching entry.
// A start and a cfg write in the same idle cycle: start wins, and cfg_ready
// stays low.
// Writing bucket_count clears all chain lengths at once. Slot contents are
// never read beyond a chain's length, so there is no clearing pass.
module chained_hash_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [30:0]           key_id,
  input  logic [63:0]           payload,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [4:0]            cfg_data,
  output logic                  done,
  output logic [1:0]            status,
  output logic [63:0]           found_payload,
  output logic [3:0]            removed_count
);
  import cht_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOOK, S_SCAN, S_WAIT} state_t;
  state_t state;

  logic [NBW-1:0]   nb;
  logic [LW-1:0]    lens [NUM_BUCKETS];
  logic [KEY_W-1:0] mem_key [SLOT_COUNT];
  logic [PAY_W-1:0] mem_pay [SLOT_COUNT];

  op_t              op;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] pay;
  logic [KEY_W-1:0] quo;       // dividend shifting out
  logic [NBW-1:0]   rem;       // partial remainder
  logic [4:0]       dcnt;
  logic [BW-1:0]    bkt;
  logic [LW-1:0]    len;
  logic [LW-1:0]    rd_i;      // read index
  logic [LW-1:0]    kept;
  logic [3:0]       removed;
  logic             rd_v;      // registered read valid
  logic [KEY_W-1:0] rk;
  logic [PAY_W-1:0] rp;

  // shared subtractor for the divider
  logic [NBW:0] trial, diff;
  assign trial = {rem, quo[KEY_W-1]};
  assign diff  = trial - {1'b0, nb};

  logic [4:0]   cfg_clamped;
  assign cfg_clamped = (cfg_data == 5'd0) ? 5'd1 :
                       (cfg_data > 5'(NUM_BUCKETS)) ? 5'(NUM_BUCKETS) : cfg_data;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  logic [SW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [KEY_W-1:0] wr_k;
  logic [PAY_W-1:0] wr_p;
  assign rd_addr = {bkt, rd_i[CW-1:0]};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {bkt, kept[CW-1:0]};
    wr_k    = rk;
    wr_p    = rp;
    // in S_LOOK bkt/len are not loaded yet; use the final remainder directly
    if (state == S_LOOK && op == OP_INSERT && lens[rem[BW-1:0]] < LW'(CHAIN_DEPTH)) begin
      wr_en   = 1'b1;
      wr_addr = {rem[BW-1:0], lens[rem[BW-1:0]][CW-1:0]};
      wr_k    = key;
      wr_p    = pay;
    end else if (state == S_SCAN && op == OP_DELETE && rd_v && rk != key) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_k;
      mem_pay[wr_addr] <= wr_p;
    end
    rk <= mem_key[rd_addr];
    rp <= mem_pay[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nb    <= NBW'(BUCKETS_RESET);
      for (int i = 0; i < NUM_BUCKETS; i++) lens[i] <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= op_t'(operation);
            key   <= key_id;
            pay   <= payload;
            quo   <= key_id;
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (cfg_valid) begin
            nb <= NBW'(cfg_clamped);
            for (int i = 0; i < NUM_BUCKETS; i++) lens[i] <= '0;
          end
        end
        S_DIV: begin
          // one quotient bit a cycle
          if (!diff[NBW]) rem <= diff[NBW-1:0];
          else            rem <= trial[NBW-1:0];
          quo  <= quo << 1;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(KEY_W - 1)) state <= S_LOOK;
        end
        S_LOOK: begin
          bkt     <= rem[BW-1:0];
          len     <= lens[rem[BW-1:0]];
          rd_i    <= '0;
          kept    <= '0;
          removed <= '0;
          rd_v    <= 1'b0;
          state   <= S_SCAN;
          // rem is final here; insert/unused finish directly
          unique case (op)
            OP_INSERT: begin
              done          <= 1'b1;
              found_payload <= '0;
              removed_count <= '0;
              state         <= S_IDLE;
              if (lens[rem[BW-1:0]] < LW'(CHAIN_DEPTH)) begin
                lens[rem[BW-1:0]] <= lens[rem[BW-1:0]] + LW'(1);
                status <= ST_OK;
              end else begin
                status <= ST_FULL;
              end
            end
            OP_UNUSED: begin
              done          <= 1'b1;
              status        <= ST_NOT_FOUND;
              found_payload <= '0;
              removed_count <= '0;
              state         <= S_IDLE;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // rd_i issues reads; rk/rp are the entry of rd_i-1 when rd_v
          rd_v <= (rd_i < len);
          if (rd_i < len) rd_i <= rd_i + LW'(1);
          if (rd_v) begin
            if (rk == key) begin
              removed <= removed + 4'd1;
              if (op == OP_SEARCH) begin
                done          <= 1'b1;
                status        <= ST_OK;
                found_payload <= rp;
                removed_count <= '0;
                state         <= S_IDLE;
              end
            end else begin
              kept <= kept + LW'(1);
            end
          end
          if (!rd_v && rd_i == len && rd_i != '0 || (len == '0)) begin
            state <= S_WAIT;
          end else if (rd_v && !(rd_i < len)) begin
            state <= S_WAIT;
          end
          if (rd_v && rk == key && op == OP_SEARCH) state <= S_IDLE;
        end
        S_WAIT: begin
          done          <= 1'b1;
          found_payload <= '0;
          state         <= S_IDLE;
          if (op == OP_DELETE) begin
            lens[bkt]     <= kept;
            status        <= (removed != 4'd0) ? ST_OK : ST_NOT_FOUND;
            removed_count <= removed;
          end else begin
            status        <= ST_NOT_FOUND;
            removed_count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_done_idle;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done while busy");

  property p_start_result;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  a_start_result: assert property (p_start_result) else $error("no work");

  property p_nb_range;
    @(posedge clk) disable iff (rst) (nb != '0) && (nb <= NBW'(NUM_BUCKETS));
  endproperty
  a_nb_range: assert property (p_nb_range) else $error("bucket count range");

  property p_found_zero;
    @(posedge clk) disable iff (rst) (done && status != ST_OK) |-> found_payload == '0;
  endproperty
  a_found_zero: assert property (p_found_zero) else $error("stray payload");
endmodule

FILE: tb/tb_chained_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table
// Self-checking bench for the chained hash table.
// ----------------------------------------------------------------------------
// Drives insert / delete / search / unused words under several bucket counts
// and compares every result word with an in-bench model of the table. A small
// scoreboard class holds the table model and the queue of pending results.
// ----------------------------------------------------------------------------
module tb_chained_hash_table;
  import cht_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] pay;
    logic [3:0]  rem;
  } result_t;

  // Table model plus pending results.
  class table_scoreboard;
    logic [30:0] keys [NUM_BUCKETS][CHAIN_DEPTH];
    logic [63:0] pays [NUM_BUCKETS][CHAIN_DEPTH];
    int          lens [NUM_BUCKETS];
    int          nbuckets;
    result_t     pending [$];

    function void clear_table(int nb);
      nbuckets = (nb < 1) ? 1 : (nb > NUM_BUCKETS) ? NUM_BUCKETS : nb;
      foreach (lens[b]) lens[b] = 0;
    endfunction

    // Note an accepted input word and queue its expected result.
    function void note_input(logic [1:0] op, logic [30:0] key, logic [63:0] pay);
      result_t r;
      int b, kept;
      b = key % nbuckets;
      r = '{st: ST_NOT_FOUND, pay: '0, rem: '0};
      case (op)
        OP_INSERT: begin
          if (lens[b] >= CHAIN_DEPTH) r.st = ST_FULL;
          else begin
            keys[b][lens[b]] = key;
            pays[b][lens[b]] = pay;
            lens[b]++;
            r.st = ST_OK;
          end
        end
        OP_DELETE: begin
          kept = 0;
          for (int i = 0; i < lens[b]; i++) begin
            if (keys[b][i] == key) r.rem++;
            else begin
              keys[b][kept] = keys[b][i];
              pays[b][kept] = pays[b][i];
              kept++;
            end
          end
          lens[b] = kept;
          if (r.rem != 0) r.st = ST_OK;
        end
        OP_SEARCH: begin
          for (int i = 0; i < lens[b]; i++) begin
            if (keys[b][i] == key) begin
              r.pay = pays[b][i];
              r.st = ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    // Returns 0 when nothing was waiting; mism counts wrong fields.
    function bit check_result(result_t got, output int mism, output result_t exp_r);
      mism = 0;
      if (pending.size() == 0) return 0;
      exp_r = pending.pop_front();
      mism += (got.st  !== exp_r.st);
      mism += (got.pay !== exp_r.pay);
      mism += (got.rem !== exp_r.rem);
      return 1;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  operation = '0;
  logic [30:0] key_id = '0;
  logic [63:0] payload = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        done;
  logic [1:0]  status;
  logic [63:0] found_payload;
  logic [3:0]  removed_count;

  chained_hash_table i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key_id(key_id), .payload(payload),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .found_payload(found_payload),
    .removed_count(removed_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  table_scoreboard sb;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Result monitor: done is a one-cycle strobe, sampled at the edge.
  always @(posedge clk) begin
    result_t got, exp_r;
    int mism;
    if (!rst && done) begin
      got = '{st: status, pay: found_payload, rem: removed_count};
      if (!sb.check_result(got, mism, exp_r))
        report("result word with nothing expected");
      else if (mism != 0)
        report($sformatf("got st=%0d pay=%h rem=%0d, want st=%0d pay=%h rem=%0d",
                         got.st, got.pay, got.rem, exp_r.st, exp_r.pay, exp_r.rem));
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One command word; sender idles at random beforehand.
  task automatic send_word(logic [1:0] op, logic [30:0] key, logic [63:0] pay);
    // start is taken low between words
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start     <= 1;
    operation <= op;
    key_id    <= key;
    payload   <= pay;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(op, key, pay);
    start <= 0;
  endtask

  // Let every result arrive, then give the block time to settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_buckets(logic [4:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.clear_table(v);
  endtask

  // Keys drawn from a small pool so chains fill, match and overflow.
  function automatic logic [30:0] pick_key();
    case ($urandom_range(9))
      0:       return 31'($urandom());
      1:       return 31'h7FFF_FFFF - 31'($urandom_range(3));
      default: return 31'($urandom_range(40));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:                 op = OP_UNUSED;
        1, 2, 3, 4, 5, 6, 7, 8: op = OP_INSERT;
        9, 10, 11, 12:     op = OP_DELETE;
        default:           op = OP_SEARCH;
      endcase
      send_word(op, pick_key(), {$urandom(), $urandom()});
    end
  endtask

  initial begin
    sb = new();
    sb.clear_table(BUCKETS_RESET);
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every operation, full chain, multi-delete, miss.
    send_word(OP_SEARCH, 31'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_DELETE, 31'd5, '0);
    send_word(OP_INSERT, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_INSERT, 31'd0, 64'h0);
    send_word(OP_SEARCH, 31'h7FFF_FFFF, '0);
    for (int i = 0; i < 9; i++)
      send_word(OP_INSERT, (i % 2) ? 31'd3 : 31'd13, 64'hA5A5_0000_0000_0000 | i);
    send_word(OP_SEARCH, 31'd13, '0);
    send_word(OP_DELETE, 31'd3, '0);
    send_word(OP_SEARCH, 31'd3, '0);
    send_word(OP_UNUSED, 31'd13, 64'h1234);
    send_word(OP_SEARCH, 31'd23, '0);

    // Extreme bucket counts, out-of-range values included.
    write_buckets(5'd0);
    random_phase(150);
    write_buckets(5'd31);
    random_phase(150);
    // Hold off until every result is back.
    drain();
    write_buckets(5'd1);
    random_phase(120);
    idle_pct = 60;
    write_buckets(5'd16);
    random_phase(150);
    write_buckets(5'd7);
    random_phase(150);
    idle_pct = 0;
    write_buckets(5'd17);
    random_phase(100);
    write_buckets(5'd10);
    random_phase(100);

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
